// File: hw/rtl/cpts_pkg.sv
// Shared types, constants and the CORDIC angle table for the pan/tilt setpoint block.
// No dependencies.
`timescale 1ns / 1ps
package cpts_pkg;
	localparam int VW = 64;
	localparam int AW = 50;
	localparam int MW = 49;
	localparam int QW = 15;

	localparam logic [MW-1:0] PDEG_PER_CENTI = 49'd10000000000;
	localparam logic signed [AW-1:0] DEG90 = 50'sd90000000000000;
	localparam logic signed [AW-1:0] DEG180 = 50'sd180000000000000;
	localparam logic [63:0] RAD_IN_PDEG = 64'd57295779513082;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

	typedef struct packed {
		logic xy_zero;
		logic x_zero;
		logic y_zero;
		logic x_pos;
		logic x_neg;
		logic y_pos;
		logic y_neg;
		logic z_pos;
	} meta_t;

	typedef struct packed {
		meta_t meta;
		logic signed [VW-1:0] leg;
		logic signed [VW-1:0] yv;
		logic signed [VW-1:0] zk;
	} item_t;

	function automatic logic signed [AW-1:0] step_angle(input int i);
		logic [63:0] r;
		begin
			case (i)
				0: r = 64'd45000000000000;
				1: r = 64'd26565051177078;
				2: r = 64'd14036243467926;
				3: r = 64'd7125016348902;
				4: r = 64'd3576334374997;
				5: r = 64'd1789910608246;
				6: r = 64'd895173710211;
				7: r = 64'd447614170861;
				8: r = 64'd223810500369;
				9: r = 64'd111905677066;
				10: r = 64'd55952891894;
				11: r = 64'd27976452617;
				12: r = 64'd13988227142;
				13: r = 64'd6994113675;
				14: r = 64'd3497056851;
				15: r = 64'd1748528427;
				16: r = 64'd874264214;
				default: r = RAD_IN_PDEG >> i;
			endcase
			return $signed(r[AW-1:0]);
		end
	endfunction
endpackage

// File: hw/rtl/cartesian_to_pan_tilt_setpoint.sv
// Top level: cartesian point to pan/tilt angles and packed motor setpoint.
// Depends on cpts_pkg, cpts_front, cpts_fifo, cpts_back.
//
//   channel  handshake             beat fields
//   input    in_valid / in_ready   coord_x, coord_y, coord_z
//   output   out_valid / out_ready pan_centi, tilt_centi, packed_setpoint
//
// One beat per cycle sustained while out_ready is high. Beats pass through the front
// register, queue, both CORDIC passes, fixup, 15 divide stages, output register.
// Reset clears all valid state; no clearing pass. Output stall freezes the back
// pipeline; the queue and front register absorb up to three beats more.
`timescale 1ns / 1ps
module cartesian_to_pan_tilt_setpoint import cpts_pkg::*; #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [23:0]  coord_x,
	input  logic signed [23:0]  coord_y,
	input  logic signed [23:0]  coord_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  pan_centi,
	output logic signed [14:0]  tilt_centi,
	output logic signed [32:0]  packed_setpoint
);
	logic  push, full, pop, q_valid;
	item_t f_item, q_item;

	cpts_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.push(push), .full(full), .item(f_item)
	);

	cpts_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wr_item(f_item), .full(full),
		.pop(pop), .rd_valid(q_valid), .rd_item(q_item)
	);

	cpts_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.src_valid(q_valid), .src_item(q_item), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.pan_centi(pan_centi), .tilt_centi(tilt_centi),
		.packed_setpoint(packed_setpoint)
	);
endmodule

// File: hw/rtl/cpts_front.sv
// Front end: takes a coordinate beat, classifies it and forms the CORDIC start vectors.
// Depends on cpts_pkg.
`timescale 1ns / 1ps
module cpts_front import cpts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [23:0]  coord_x,
	input  logic signed [23:0]  coord_y,
	input  logic signed [23:0]  coord_z,
	output logic                push,
	input  logic                full,
	output item_t               item
);
	logic   valid_s1;
	item_t  item_s1;
	item_t  nxt;
	logic [23:0] ax, ay;
	logic signed [55:0] zprod;

	assign push = valid_s1 && !full;
	assign in_ready = !valid_s1 || !full;
	assign item = item_s1;

	always_comb begin
		ax = coord_x[23] ? 24'(-coord_x) : coord_x;
		ay = coord_y[23] ? 24'(-coord_y) : coord_y;
		zprod = 56'(coord_z) * 56'(GAIN_Q30);
		nxt.meta.x_zero  = coord_x == 24'sd0;
		nxt.meta.y_zero  = coord_y == 24'sd0;
		nxt.meta.xy_zero = nxt.meta.x_zero && nxt.meta.y_zero;
		nxt.meta.x_neg   = coord_x[23];
		nxt.meta.x_pos   = !coord_x[23] && !nxt.meta.x_zero;
		nxt.meta.y_neg   = coord_y[23];
		nxt.meta.y_pos   = !coord_y[23] && !nxt.meta.y_zero;
		nxt.meta.z_pos   = !coord_z[23] && coord_z != 24'sd0;
		nxt.leg = $signed({8'd0, ax, 32'd0});
		nxt.yv  = $signed({8'd0, ay, 32'd0});
		nxt.zk  = $signed({{6{zprod[55]}}, zprod, 2'b00});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= nxt;
		end
	end
endmodule

// File: hw/rtl/cpts_fifo.sv
// Two-entry queue that decouples the front end from the CORDIC back end.
// Depends on cpts_pkg.
`timescale 1ns / 1ps
module cpts_fifo import cpts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  item_t  wr_item,
	output logic   full,
	input  logic   pop,
	output logic   rd_valid,
	output item_t  rd_item
);
	item_t       mem_q [0:1];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	assign full = count_q == 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end
endmodule

// File: hw/rtl/cpts_back.sv
// Back end: pan and tilt CORDIC pipelines, angle fixup, division to hundredths, packing.
// Depends on cpts_pkg.
`timescale 1ns / 1ps
module cpts_back import cpts_pkg::*; #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	input  item_t               src_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  pan_centi,
	output logic signed [14:0]  tilt_centi,
	output logic signed [32:0]  packed_setpoint
);
	localparam int NS = 2 * CORDIC_STEPS;

	logic en;
	logic                 cv   [0:NS];
	meta_t                cm   [0:NS];
	logic signed [VW-1:0] cx   [0:NS];
	logic signed [VW-1:0] cy   [0:NS];
	logic signed [VW-1:0] cz   [0:NS];
	logic signed [AW-1:0] ca   [0:NS];
	logic signed [AW-1:0] cpa  [0:NS];

	logic           dv   [0:QW];
	logic [MW-1:0]  drp  [0:QW];
	logic [MW-1:0]  drt  [0:QW];
	logic [QW-1:0]  dqp  [0:QW];
	logic [QW-1:0]  dqt  [0:QW];
	logic           dsp  [0:QW];
	logic           dst  [0:QW];

	logic                 out_valid_q;
	logic signed [15:0]   pan_q;
	logic signed [14:0]   tilt_q;
	logic signed [32:0]   setp_q;

	assign en = !out_valid_q || out_ready;
	assign pop = en && src_valid;

	assign cv[0]  = src_valid;
	assign cm[0]  = src_item.meta;
	assign cx[0]  = src_item.leg;
	assign cy[0]  = src_item.yv;
	assign cz[0]  = src_item.zk;
	assign ca[0]  = '0;
	assign cpa[0] = '0;

	for (genvar k = 0; k < NS; k++) begin : g_cordic
		localparam int I = (k < CORDIC_STEPS) ? k : k - CORDIC_STEPS;
		logic signed [VW-1:0] yin;
		logic signed [AW-1:0] ain;
		always_comb begin
			yin = (k == CORDIC_STEPS) ? cz[k] : cy[k];
			ain = (k == CORDIC_STEPS) ? '0 : ca[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv[k+1] <= 1'b0;
			end else if (en) begin
				cv[k+1] <= cv[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cm[k+1] <= cm[k];
				cz[k+1] <= cz[k];
				cpa[k+1] <= (k == CORDIC_STEPS) ? ca[k] : cpa[k];
				if (!yin[VW-1]) begin
					cx[k+1] <= cx[k] + (yin >>> I);
					cy[k+1] <= yin - (cx[k] >>> I);
					ca[k+1] <= ain + step_angle(I);
				end else begin
					cx[k+1] <= cx[k] - (yin >>> I);
					cy[k+1] <= yin + (cx[k] >>> I);
					ca[k+1] <= ain - step_angle(I);
				end
			end
		end
	end

	meta_t                fm;
	logic signed [AW-1:0] ap, pan_p, tilt_p, pan_abs, tilt_abs;
	always_comb begin
		fm = cm[NS];
		if (fm.x_zero) ap = DEG90;
		else if (fm.y_zero) ap = '0;
		else ap = cpa[NS];
		if (fm.xy_zero) pan_p = '0;
		else if (!fm.x_neg) pan_p = fm.y_neg ? -ap : ap;
		else pan_p = DEG180 + (fm.y_pos ? -ap : ap);
		if (!fm.z_pos) tilt_p = '0;
		else if (fm.xy_zero) tilt_p = DEG90;
		else tilt_p = (fm.y_neg && fm.x_pos) ? -ca[NS] : ca[NS];
		pan_abs = pan_p[AW-1] ? -pan_p : pan_p;
		tilt_abs = tilt_p[AW-1] ? -tilt_p : tilt_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (en) begin
			dv[0] <= cv[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drp[0] <= pan_abs[MW-1:0];
			drt[0] <= tilt_abs[MW-1:0];
			dsp[0] <= pan_p[AW-1];
			dst[0] <= tilt_p[AW-1];
			dqp[0] <= '0;
			dqt[0] <= '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		localparam logic [MW-1:0] DS = PDEG_PER_CENTI << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[k+1] <= 1'b0;
			end else if (en) begin
				dv[k+1] <= dv[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dsp[k+1] <= dsp[k];
				dst[k+1] <= dst[k];
				if (drp[k] >= DS) begin
					drp[k+1] <= drp[k] - DS;
					dqp[k+1] <= dqp[k] | (QW'(1) << B);
				end else begin
					drp[k+1] <= drp[k];
					dqp[k+1] <= dqp[k];
				end
				if (drt[k] >= DS) begin
					drt[k+1] <= drt[k] - DS;
					dqt[k+1] <= dqt[k] | (QW'(1) << B);
				end else begin
					drt[k+1] <= drt[k];
					dqt[k+1] <= dqt[k];
				end
			end
		end
	end

	logic signed [15:0] pan_f;
	logic signed [14:0] tilt_f;
	always_comb begin
		pan_f = dsp[QW] ? -$signed({1'b0, dqp[QW]}) : $signed({1'b0, dqp[QW]});
		tilt_f = dst[QW] ? -$signed({1'b0, dqt[QW][13:0]}) : $signed({1'b0, dqt[QW][13:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pan_q <= pan_f;
			tilt_q <= tilt_f;
			setp_q <= 33'(pan_f) * 33'sd100000 + 33'(tilt_f);
		end
	end

	assign out_valid = out_valid_q;
	assign pan_centi = pan_q;
	assign tilt_centi = tilt_q;
	assign packed_setpoint = setp_q;
endmodule

// File: hw/rtl/cpts_checker.sv
// Port-level checker for the pan/tilt setpoint block, with its bind.
// Depends on cartesian_to_pan_tilt_setpoint.
`timescale 1ns / 1ps
module cpts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [15:0]  pan_centi,
	input logic signed [14:0]  tilt_centi,
	input logic signed [32:0]  packed_setpoint
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_setpoint))
		else $error("output beat changed while stalled");

	a_pack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> packed_setpoint == 33'(pan_centi) * 33'sd100000 + 33'(tilt_centi))
		else $error("setpoint does not match angles");

	a_pan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pan_centi >= -16'sd9000 && pan_centi <= 16'sd27000)
		else $error("pan out of range");

	a_tilt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tilt_centi >= -15'sd9000 && tilt_centi <= 15'sd9000)
		else $error("tilt out of range");
endmodule

bind cartesian_to_pan_tilt_setpoint cpts_checker u_cpts_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.pan_centi(pan_centi), .tilt_centi(tilt_centi), .packed_setpoint(packed_setpoint)
);

// File: tb/cartesian_to_pan_tilt_setpoint_tb.sv
// Testbench for cartesian_to_pan_tilt_setpoint: directed and random points, bursty input, stalled output.
// Expected angles come from a local CORDIC predictor; depends on the RTL top level only.
`timescale 1ns / 1ps
module cartesian_to_pan_tilt_setpoint_tb;
	localparam int STEPS = 20;
	localparam int LATENCY = 2 * STEPS + 19;
	localparam int MAX_CYCLES = 400000;
	localparam longint PDEG_CENTI = 64'sd10000000000;
	localparam longint PDEG_90 = 64'sd90000000000000;
	localparam longint PDEG_180 = 64'sd180000000000000;
	localparam longint GAIN = 64'sd1768195363;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} point_t;

	typedef struct {
		logic signed [15:0] pan;
		logic signed [14:0] tilt;
		logic signed [32:0] setp;
	} angles_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [23:0] coord_x = 0, coord_y = 0, coord_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] pan_centi;
	logic signed [14:0] tilt_centi;
	logic signed [32:0] packed_setpoint;

	point_t pending_points[$];
	angles_t expected_angles[$];
	int errors = 0;
	int cycle_count = 0;
	bit stim_done = 0;
	bit hold_send = 0;
	int burst_left = 0, gap_left = 0;

	cartesian_to_pan_tilt_setpoint #(.CORDIC_STEPS(STEPS)) DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint arc_step(int i);
		longint tab[17] = '{64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926,
			64'sd7125016348902, 64'sd3576334374997, 64'sd1789910608246,
			64'sd895173710211, 64'sd447614170861, 64'sd223810500369,
			64'sd111905677066, 64'sd55952891894, 64'sd27976452617,
			64'sd13988227142, 64'sd6994113675, 64'sd3497056851,
			64'sd1748528427, 64'sd874264214};
		if (i < 17)
			return tab[i];
		return longint'(64'd57295779513082 >> i);
	endfunction

	function automatic longint vectoring(ref longint lx, input longint ly);
		longint vx, vy, dx, dy, ang;
		vx = lx;
		vy = ly;
		ang = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx; vy -= dy; ang += arc_step(i);
			end else begin
				vx -= dx; vy += dy; ang -= arc_step(i);
			end
		end
		lx = vx;
		return ang;
	endfunction

	function automatic angles_t aim_point(point_t p);
		longint x, y, z, pan_p, tilt_p, leg, a, pc, tc;
		angles_t r;
		x = p.x; y = p.y; z = p.z;
		pan_p = 0;
		tilt_p = 0;
		if (x == 0 && y == 0) begin
			tilt_p = (z > 0) ? PDEG_90 : 0;
		end else begin
			leg = (x < 0 ? -x : x) * 64'sd4294967296;
			a = vectoring(leg, (y < 0 ? -y : y) * 64'sd4294967296);
			if (x == 0)
				a = PDEG_90;
			else if (y == 0)
				a = 0;
			if (x >= 0)
				pan_p = (y < 0) ? -a : a;
			else
				pan_p = PDEG_180 + ((y > 0) ? -a : a);
			if (z > 0) begin
				tilt_p = vectoring(leg, z * GAIN * 4);
				if (y < 0 && x > 0)
					tilt_p = -tilt_p;
			end
		end
		pc = pan_p / PDEG_CENTI;
		tc = tilt_p / PDEG_CENTI;
		r.pan = pc[15:0];
		r.tilt = tc[14:0];
		r.setp = 33'(100000 * pc + tc);
		return r;
	endfunction

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'($urandom_range(0, 40)) - 24'sd20;
			1: return 24'sh7FFFFF - 24'($urandom_range(0, 3));
			2: return 24'sh800000 + 24'($urandom_range(0, 3));
			3: return 24'($urandom_range(0, 2000)) - 24'sd1000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic add_point(logic signed [23:0] x, logic signed [23:0] y,
			logic signed [23:0] z);
		point_t p;
		p.x = x; p.y = y; p.z = z;
		pending_points.push_back(p);
	endtask

	initial begin
		point_t p;
		add_point(0, 0, 0);
		add_point(0, 0, 5);
		add_point(0, 0, -5);
		add_point(0, 7, 3);
		add_point(0, -7, 3);
		add_point(9, 0, 4);
		add_point(-9, 0, 4);
		add_point(100, 100, 100);
		add_point(-100, 100, 100);
		add_point(-100, -100, 100);
		add_point(100, -100, 100);
		add_point(100, -100, -100);
		add_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		add_point(24'sh800000, 24'sh800000, 24'sh800000);
		add_point(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
		add_point(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
		add_point(1, 24'sh7FFFFF, 24'sh7FFFFF);
		add_point(24'sh7FFFFF, 1, 1);
		add_point(-1, -1, 24'sh7FFFFF);
		add_point(24'sh555555, 24'shAAAAAA, 24'sh555555);
		add_point(24'shAAAAAA, 24'sh555555, 24'shAAAAAA);
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (450) begin
			if (pending_points.size() == 230) begin
				wait (pending_points.size() == 0);
				@(posedge clk);
				hold_send = 1;
				wait (expected_angles.size() == 0);
				hold_send = 0;
			end
			add_point(rand_coord(), rand_coord(), rand_coord());
		end
		stim_done = 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_angles.push_back(aim_point('{coord_x, coord_y, coord_z}));
				void'(pending_points.pop_front());
			end
			if ((!in_valid || in_ready) && !hold_send) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
				if (pending_points.size() > (in_valid && in_ready ? 0 : 0)
						&& burst_left > 0 && pending_points.size() > 0) begin
					in_valid <= 1;
					coord_x <= pending_points[0].x;
					coord_y <= pending_points[0].y;
					coord_z <= pending_points[0].z;
					burst_left--;
				end else begin
					in_valid <= 0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_angles.size() == 0) begin
					$display("%t unexpected beat pan=%0d tilt=%0d", $time, pan_centi,
						tilt_centi);
					errors++;
				end else begin
					angles_t e;
					e = expected_angles.pop_front();
					if (pan_centi != e.pan) begin
						$display("%t pan exp=%0d got=%0d", $time, e.pan, pan_centi);
						errors++;
					end
					if (tilt_centi != e.tilt) begin
						$display("%t tilt exp=%0d got=%0d", $time, e.tilt, tilt_centi);
						errors++;
					end
					if (packed_setpoint != e.setp) begin
						$display("%t setpoint exp=%0d got=%0d", $time, e.setp,
							packed_setpoint);
						errors++;
					end
				end
			end
			case ((cycle_count / 200) % 3)
				0: out_ready <= 1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	initial begin
		wait (stim_done && pending_points.size() == 0);
		@(posedge clk);
		wait (expected_angles.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_angles.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end
endmodule

// File: sim.f
hw/rtl/cpts_pkg.sv
hw/rtl/cpts_front.sv
hw/rtl/cpts_fifo.sv
hw/rtl/cpts_back.sv
hw/rtl/cartesian_to_pan_tilt_setpoint.sv
hw/rtl/cpts_checker.sv
tb/cartesian_to_pan_tilt_setpoint_tb.sv
